[rtl/core/tolerance_match_and_consume_table_top_defines.svh]
// assertion macros for the tolerance match table
`ifndef TOLERANCE_MATCH_AND_CONSUME_TABLE_TOP_DEFINES_SVH
`define TOLERANCE_MATCH_AND_CONSUME_TABLE_TOP_DEFINES_SVH
// condition implies consequence in the same cycle
`define TMCT_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("tmct check failed");
// condition implies consequence in the next cycle
`define TMCT_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("tmct check failed");
`endif

[rtl/core/tmct_pkg.sv]
// shared constants of the tolerance match table
`default_nettype none
package tmct_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int OP_W = 2;
    localparam int SAMPLE_W = 3;
    localparam int MASS_W = 32;
    localparam int TIME_W = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_W = 56;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOL_FRAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WIN = 2'd2;

    localparam logic [31:0] RST_TOL_FRAC = 32'd42950;
    localparam logic [15:0] RST_MIN_TOL = 16'd100;
    localparam logic [15:0] RST_TIME_WIN = 16'd1311;
endpackage
`default_nettype wire

[rtl/core/tmct_cell.sv]
// one table entry plus one stage of the query chain
`default_nettype none
module tmct_cell #(
    parameter int IDX_W = 10,
    parameter int CELL_IDX = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load_we,
    input  wire logic [tmct_pkg::SAMPLE_W-1:0] load_sample,
    input  wire logic [tmct_pkg::MASS_W-1:0]   load_mass,
    input  wire logic [tmct_pkg::TIME_W-1:0]   load_time,
    input  wire logic                          clear,
    input  wire logic [tmct_pkg::TIME_W-1:0]   time_window,
    input  wire logic                          q_valid_in,
    input  wire logic                          q_hit_in,
    input  wire logic [IDX_W-1:0]              q_idx_in,
    input  wire logic [tmct_pkg::SAMPLE_W-1:0] q_sample_in,
    input  wire logic [tmct_pkg::MASS_W-1:0]   q_mass_in,
    input  wire logic [tmct_pkg::MASS_W-1:0]   q_tol_in,
    input  wire logic [tmct_pkg::TIME_W-1:0]   q_time_in,
    output logic                               q_valid_out,
    output logic                               q_hit_out,
    output logic [IDX_W-1:0]                   q_idx_out,
    output logic [tmct_pkg::SAMPLE_W-1:0]      q_sample_out,
    output logic [tmct_pkg::MASS_W-1:0]        q_mass_out,
    output logic [tmct_pkg::MASS_W-1:0]        q_tol_out,
    output logic [tmct_pkg::TIME_W-1:0]        q_time_out
);
    import tmct_pkg::*;

    logic                live_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [MASS_W-1:0]   mass_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [MASS_W-1:0]   mdiff;
    logic [TIME_W-1:0]   tdiff;
    logic                match;

    assign mdiff = (mass_reg >= q_mass_in) ? mass_reg - q_mass_in : q_mass_in - mass_reg;
    assign tdiff = (time_reg >= q_time_in) ? time_reg - q_time_in : q_time_in - time_reg;
    assign match = q_valid_in && !q_hit_in && live_reg && (sample_reg == q_sample_in)
                   && (mdiff <= q_tol_in) && (tdiff < time_window);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 1'b0;
            q_valid_out <= 1'b0;
        end else begin
            q_valid_out <= q_valid_in;
            if (clear) begin
                live_reg <= 1'b0;
            end else if (load_we) begin
                live_reg <= 1'b1;
            end else if (match) begin
                live_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            sample_reg <= load_sample;
            mass_reg <= load_mass;
            time_reg <= load_time;
        end
        q_hit_out <= q_hit_in | match;
        q_idx_out <= match ? IDX_W'(CELL_IDX) : q_idx_in;
        q_sample_out <= q_sample_in;
        q_mass_out <= q_mass_in;
        q_tol_out <= q_tol_in;
        q_time_out <= q_time_in;
    end
endmodule
`default_nettype wire

[rtl/core/tolerance_match_and_consume_table_top.sv]
// top level of the tolerance match table: sequencer, registers and cell chain
//
// channel | dir | fields
// s_      | in  | op, sample_id, item_mass, item_time
// m_      | out | found, entry_index, status
// cfg_    | in  | tolerance_fraction, min_tolerance, time_window
//
// load, clear and no-op transactions: result valid in the cycle after accept
// query: tolerance product registered at the accept edge; cell i compares while the
// query sits at chain index i, and the result is registered when it leaves the last cell
// one transaction at a time; input is held off until the result is taken
// aresetn is synchronous active low, clears live bits, count and control
`default_nettype none
module tolerance_match_and_consume_table_top #(
    parameter int TABLE_DEPTH = tmct_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = $clog2(TABLE_DEPTH),
    parameter int OUT_W = ((IDX_W + 3 + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // op[1:0], sample_id[4:2], item_mass[36:5], item_time[52:37], zero pad
    input  wire logic [tmct_pkg::IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found, entry_index, status, zero pad
    output logic [OUT_W-1:0]                     m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [tmct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tmct_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [31:0] tol_frac_reg;
    logic [15:0] min_tol_reg;
    logic [15:0] time_win_reg;

    // input fields
    logic [OP_W-1:0]     in_op;
    logic [SAMPLE_W-1:0] in_sample;
    logic [MASS_W-1:0]   in_mass;
    logic [TIME_W-1:0]   in_time;
    logic                s_xfer;

    // latched query
    logic [SAMPLE_W-1:0] q_sample_reg;
    logic [MASS_W-1:0]   q_mass_reg;
    logic [TIME_W-1:0]   q_time_reg;
    logic [63:0]         prod_reg;
    logic [MASS_W-1:0]   tol_raw;
    logic [MASS_W-1:0]   tol_sel;

    logic [CNT_W-1:0]    count_reg;
    logic                full;
    logic                load_go;
    logic                clear_go;

    // result register
    logic                out_valid_reg;
    logic                out_found_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // chain wiring, index 0 is the injection point
    logic                c_valid  [TABLE_DEPTH+1];
    logic                c_hit    [TABLE_DEPTH+1];
    logic [IDX_W-1:0]    c_idx    [TABLE_DEPTH+1];
    logic [SAMPLE_W-1:0] c_sample [TABLE_DEPTH+1];
    logic [MASS_W-1:0]   c_mass   [TABLE_DEPTH+1];
    logic [MASS_W-1:0]   c_tol    [TABLE_DEPTH+1];
    logic [TIME_W-1:0]   c_time   [TABLE_DEPTH+1];
    logic                scan_done;

    assign in_op = s_tdata[1:0];
    assign in_sample = s_tdata[4:2];
    assign in_mass = s_tdata[36:5];
    assign in_time = s_tdata[52:37];

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign s_xfer = s_tvalid && s_tready;
    assign full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign load_go = s_xfer && (in_op == OP_LOAD) && !full;
    assign clear_go = s_xfer && (in_op == OP_CLEAR);
    assign scan_done = c_valid[TABLE_DEPTH];

    // mass tolerance floor
    assign tol_raw = prod_reg[63:32];
    assign tol_sel = (tol_raw < MASS_W'(min_tol_reg)) ? MASS_W'(min_tol_reg) : tol_raw;

    // one query enters the chain while the sequencer is in S_MUL
    assign c_valid[0] = (state_reg == S_MUL);
    assign c_hit[0] = 1'b0;
    assign c_idx[0] = '0;
    assign c_sample[0] = q_sample_reg;
    assign c_mass[0] = q_mass_reg;
    assign c_tol[0] = tol_sel;
    assign c_time[0] = q_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_frac_reg <= RST_TOL_FRAC;
            min_tol_reg <= RST_MIN_TOL;
            time_win_reg <= RST_TIME_WIN;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TOL_FRAC: tol_frac_reg <= cfg_wdata;
                REG_MIN_TOL: min_tol_reg <= cfg_wdata[15:0];
                REG_TIME_WIN: time_win_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer && (in_op == OP_QUERY)) state_next = S_MUL;
            end
            S_MUL: state_next = S_SCAN;
            S_SCAN: begin
                if (scan_done) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_go) begin
                count_reg <= '0;
            end else if (load_go) begin
                count_reg <= count_reg + 1'b1;
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end else if ((s_xfer && (in_op != OP_QUERY)) || scan_done) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // result payload and query latch
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            q_sample_reg <= in_sample;
            q_mass_reg <= in_mass;
            q_time_reg <= in_time;
            // tolerance product, one multiply registered with the query
            prod_reg <= 64'(in_mass) * 64'(tol_frac_reg);
            out_found_reg <= 1'b0;
            out_idx_reg <= '0;
            out_status_reg <= ST_OK;
            if (in_op == OP_LOAD) begin
                if (full) begin
                    out_status_reg <= ST_FULL;
                end else begin
                    out_idx_reg <= count_reg[IDX_W-1:0];
                end
            end
        end else if (scan_done) begin
            out_found_reg <= c_hit[TABLE_DEPTH];
            out_idx_reg <= c_hit[TABLE_DEPTH] ? c_idx[TABLE_DEPTH] : '0;
            out_status_reg <= c_hit[TABLE_DEPTH] ? ST_OK : ST_NOMATCH;
        end
    end

    // row of entry cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        tmct_cell #(
            .IDX_W(IDX_W),
            .CELL_IDX(i)
        ) u_cell (
            .aclk(aclk),
            .aresetn(aresetn),
            .load_we(load_go && (count_reg == CNT_W'(i))),
            .load_sample(in_sample),
            .load_mass(in_mass),
            .load_time(in_time),
            .clear(clear_go),
            .time_window(time_win_reg),
            .q_valid_in(c_valid[i]),
            .q_hit_in(c_hit[i]),
            .q_idx_in(c_idx[i]),
            .q_sample_in(c_sample[i]),
            .q_mass_in(c_mass[i]),
            .q_tol_in(c_tol[i]),
            .q_time_in(c_time[i]),
            .q_valid_out(c_valid[i+1]),
            .q_hit_out(c_hit[i+1]),
            .q_idx_out(c_idx[i+1]),
            .q_sample_out(c_sample[i+1]),
            .q_mass_out(c_mass[i+1]),
            .q_tol_out(c_tol[i+1]),
            .q_time_out(c_time[i+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_W'({out_status_reg, out_idx_reg, out_found_reg});
endmodule
`default_nettype wire

[rtl/core/tmct_checker.sv]
// port-level checks for the tolerance match table, bound to the top level
`default_nettype none
`include "tolerance_match_and_consume_table_top_defines.svh"
module tmct_checker #(
    parameter int IDX_W = 10,
    parameter int OUT_W = 16
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [OUT_W-1:0]          m_tdata
);
    import tmct_pkg::*;

    logic                found;
    logic [STATUS_W-1:0] status;

    assign found = m_tdata[0];
    assign status = m_tdata[IDX_W+2:IDX_W+1];

    `TMCT_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `TMCT_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `TMCT_ASSERT_SAME(a_found_ok, aclk, aresetn, m_tvalid && found, status == ST_OK)
    `TMCT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind tolerance_match_and_consume_table_top tmct_checker #(
    .IDX_W(IDX_W),
    .OUT_W(OUT_W)
) u_tmct_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);
`default_nettype wire

[tb/tmct_checker.sv]
// checker for the tolerance match table: predicts each result and compares the result channel
`timescale 1ns / 1ps
module tmct_tb_checker #(
    parameter int TABLE_DEPTH = tmct_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [tmct_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [15:0]                     m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [tmct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tmct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                   fail_count,
    output int                                   pending
);
    import tmct_pkg::*;

    typedef struct packed {
        logic          found;
        logic [9:0]    entry_index;
        logic [STATUS_W-1:0] status;
    } match_result_t;

    logic [MASS_W-1:0]   tbl_mass   [TABLE_DEPTH];
    logic [TIME_W-1:0]   tbl_time   [TABLE_DEPTH];
    logic [SAMPLE_W-1:0] tbl_sample [TABLE_DEPTH];
    logic                tbl_live   [TABLE_DEPTH];
    int                  tbl_count;
    logic [31:0]         tol_frac;
    logic [15:0]         min_tol;
    logic [15:0]         time_win;
    match_result_t       expected_results[$];

    initial begin
        fail_count = 0;
        pending = 0;
        tbl_count = 0;
        foreach (tbl_live[i]) tbl_live[i] = 1'b0;
        tol_frac = RST_TOL_FRAC;
        min_tol = RST_MIN_TOL;
        time_win = RST_TIME_WIN;
    end

    // lowest live entry of the sample within mass tolerance and time window
    function automatic match_result_t lookup_and_consume(logic [SAMPLE_W-1:0] smp,
            logic [MASS_W-1:0] mass, logic [TIME_W-1:0] tm);
        match_result_t r;
        logic [63:0] prod;
        logic [31:0] tol;
        logic [31:0] dm;
        logic [15:0] dt;
        r = '{found: 1'b0, entry_index: '0, status: ST_NOMATCH};
        prod = 64'(mass) * 64'(tol_frac);
        tol = prod[63:32];
        if (tol < 32'(min_tol)) tol = 32'(min_tol);
        for (int i = 0; i < tbl_count; i++) begin
            if (!tbl_live[i] || tbl_sample[i] != smp) continue;
            dm = (tbl_mass[i] >= mass) ? tbl_mass[i] - mass : mass - tbl_mass[i];
            if (dm > tol) continue;
            dt = (tbl_time[i] >= tm) ? tbl_time[i] - tm : tm - tbl_time[i];
            if (dt < time_win) begin
                tbl_live[i] = 1'b0;
                r = '{found: 1'b1, entry_index: 10'(i), status: ST_OK};
                break;
            end
        end
        return r;
    endfunction

    function automatic match_result_t apply_item(logic [IN_W-1:0] d);
        match_result_t r;
        logic [OP_W-1:0] op;
        r = '{found: 1'b0, entry_index: '0, status: ST_OK};
        op = d[1:0];
        case (op)
            OP_LOAD: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_sample[tbl_count] = d[4:2];
                    tbl_mass[tbl_count] = d[36:5];
                    tbl_time[tbl_count] = d[52:37];
                    tbl_live[tbl_count] = 1'b1;
                    r.entry_index = 10'(tbl_count);
                    tbl_count++;
                end
            end
            OP_QUERY: r = lookup_and_consume(d[4:2], d[36:5], d[52:37]);
            OP_CLEAR: begin
                tbl_count = 0;
                foreach (tbl_live[i]) tbl_live[i] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        match_result_t exp_r;
        match_result_t got;
        match_result_t pred;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TOL_FRAC: tol_frac = cfg_wdata;
                    REG_MIN_TOL:  min_tol = cfg_wdata[15:0];
                    REG_TIME_WIN: time_win = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pred = apply_item(s_tdata);
                expected_results = {expected_results, pred};
            end
            if (m_tvalid && m_tready) begin
                got = '{found: m_tdata[0], entry_index: m_tdata[10:1],
                        status: m_tdata[12:11]};
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.found !== exp_r.found) begin
                        $error("found: expected %0d, got %0d", exp_r.found, got.found);
                        fail_count++;
                    end
                    if (got.entry_index !== exp_r.entry_index) begin
                        $error("entry_index: expected %0d, got %0d",
                               exp_r.entry_index, got.entry_index);
                        fail_count++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end
endmodule

[tb/tb.sv]
// testbench top for the tolerance match table: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb;
    import tmct_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 2000;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // op[1:0], sample_id[4:2], item_mass[36:5], item_time[52:37], zero pad
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // found[0], entry_index[10:1], status[12:11], zero pad
    logic [15:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;

    tolerance_match_and_consume_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    tmct_tb_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    longint cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: stall mode changes now and then; mode 0 gives stretches with no stalls
    logic long_hold_req = 1'b0;
    logic long_hold = 1'b0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(5, 200);
        end
        rx_mode_left--;
        if (long_hold) m_tready <= 1'b0;
        else case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // long receiver hold-off, counted in its own process
    initial begin
        wait (long_hold_req);
        long_hold = 1'b1;
        repeat (3000) @(negedge aclk);
        long_hold = 1'b0;
    end

    // what has been loaded since the last clear, used to aim queries at real entries
    logic [SAMPLE_W-1:0] ld_sample[$];
    logic [MASS_W-1:0]   ld_mass[$];
    logic [TIME_W-1:0]   ld_time[$];
    int burst_left = 0;
    int items_sent = 0;

    // one transaction on the input channel, with bursts and random gaps
    task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                             logic [MASS_W-1:0] mass, logic [TIME_W-1:0] tm);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end else begin
            @(negedge aclk);
        end
        s_tdata = {3'b000, tm, mass, smp, op};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
        if (op == OP_LOAD && ld_mass.size() < DEPTH) begin
            ld_sample = {ld_sample, smp};
            ld_mass = {ld_mass, mass};
            ld_time = {ld_time, tm};
        end else if (op == OP_CLEAR) begin
            ld_sample.delete();
            ld_mass.delete();
            ld_time.delete();
        end
    endtask

    // sender pause until every expected result has come back
    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
        repeat (DEPTH + 8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // query aimed near a loaded entry, or plain noise
    task automatic send_query;
        int k;
        logic [MASS_W-1:0] m;
        logic [TIME_W-1:0] t;
        if (ld_mass.size() > 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, ld_mass.size() - 1);
            m = ld_mass[k] + MASS_W'($urandom_range(0, 300)) - MASS_W'(150);
            t = TIME_W'(32'(ld_time[k]) + $urandom_range(0, 3000) - 32'd1500);
            send_item(OP_QUERY, ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom_range(0, 7))
                      : ld_sample[k], m, t);
        end else begin
            send_item(OP_QUERY, SAMPLE_W'($urandom_range(0, 7)), $urandom,
                      TIME_W'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        int phase;
        int n;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TOL_FRAC;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part at reset settings: tolerance floor is 100, window 1311
        send_item(OP_LOAD, 3'd0, 32'h0000_0000, 16'h0000);
        send_item(OP_LOAD, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_QUERY, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_QUERY, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);  // already consumed
        send_item(OP_QUERY, 3'd0, 32'd100, 16'd1310);         // mass and time at the edge
        send_item(OP_LOAD, 3'd3, 32'd1_000_000, 16'd5000);
        send_item(OP_LOAD, 3'd3, 32'd1_000_000, 16'd5000);   // duplicate, lowest wins
        send_item(OP_QUERY, 3'd3, 32'd1_000_101, 16'd5000);  // one past mass tolerance
        send_item(OP_QUERY, 3'd3, 32'd1_000_000, 16'd3689);  // time diff equals window
        send_item(OP_QUERY, 3'd4, 32'd1_000_000, 16'd5000);  // wrong sample
        send_item(OP_QUERY, 3'd3, 32'd999_900, 16'd6310);
        send_item(OP_QUERY, 3'd3, 32'd1_000_100, 16'd3690);
        send_item(OP_QUERY, 3'd3, 32'd1_000_000, 16'd5000);  // both used up
        send_item(2'd3, 3'd5, 32'hDEAD_BEEF, 16'h1234);      // unused op code
        send_item(OP_LOAD, 3'd5, 32'hFFFF_FFFF, 16'h8000);
        send_item(OP_CLEAR, 3'd0, 32'd0, 16'd0);
        send_item(OP_QUERY, 3'd5, 32'hFFFF_FFFF, 16'h8000);  // gone after clear
        send_item(OP_LOAD, 3'd6, 32'hFFFF_FFFF, 16'h8000);   // index restarts at zero
        send_item(OP_QUERY, 3'd6, 32'hFFF0_0000, 16'h8000);  // large mass, wide relative tol
        drain();

        // random part in phases; settings change only while idle
        phase = 0;
        while (items_sent < RANDOM_ITEMS + 19) begin
            case (phase)
                0: begin
                    write_reg(REG_TOL_FRAC, 32'hFFFF_FFFF);
                    write_reg(REG_MIN_TOL, 32'hFFFF);
                    write_reg(REG_TIME_WIN, 32'hFFFF);
                end
                1: begin
                    write_reg(REG_TOL_FRAC, 32'd0);
                    write_reg(REG_MIN_TOL, 32'd0);
                    write_reg(REG_TIME_WIN, 32'd0);
                end
                default: begin
                    write_reg(REG_TOL_FRAC, ($urandom_range(0, 5) == 0) ? $urandom
                              : $urandom_range(0, 1 << 20));
                    write_reg(REG_MIN_TOL, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                              : $urandom_range(0, 200));
                    write_reg(REG_TIME_WIN, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                              : $urandom_range(1, 2000));
                end
            endcase
            if (phase == 4) long_hold_req = 1'b1;
            if ($urandom_range(0, 2) != 0) send_item(OP_CLEAR, SAMPLE_W'($urandom_range(0, 7)),
                                                      $urandom, TIME_W'($urandom_range(0, 65535)));
            // one phase fills the table past its depth to reach the full case
            n = (phase == 3) ? DEPTH + 6 : $urandom_range(1, 40);
            repeat (n) send_item(OP_LOAD, SAMPLE_W'($urandom_range(0, 7)), $urandom,
                                 TIME_W'($urandom_range(0, 65535)));
            n = $urandom_range(1, 15);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0: send_item(2'd3, SAMPLE_W'($urandom_range(0, 7)), $urandom,
                                 TIME_W'($urandom_range(0, 65535)));
                    1: send_item(OP_LOAD, SAMPLE_W'($urandom_range(0, 7)), $urandom,
                                 TIME_W'($urandom_range(0, 65535)));
                    default: send_query();
                endcase
            end
            drain();
            phase++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[tolerance_match_and_consume_table_top.f]
+incdir+rtl/core
rtl/core/tmct_pkg.sv
rtl/core/tmct_cell.sv
rtl/core/tolerance_match_and_consume_table_top.sv
rtl/core/tmct_checker.sv
tb/tmct_checker.sv
tb/tb.sv
